[rtl/pwdt_pkg.sv]
// Package for the pin watchdog timer.
// Holds request codes, register indexes, reset values and the configuration struct.
package pwdt_pkg;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_KICK = 2'd1;
	localparam logic [1:0] REQ_ARM  = 2'd2;

	localparam int unsigned REG_ADDR_W = 5;
	localparam int unsigned REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_NORMAL_PIN_STATE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_PIN_STATE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RESET_AFTER_TIMEOUT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALL_PINS_MODE       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ALL_PINS_PATTERN    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RESET_DELAY_MS      = 3'd5;

	localparam logic [1:0]  RST_NORMAL_PIN_STATE  = 2'd2;
	localparam logic [1:0]  RST_TIMEOUT_PIN_STATE = 2'd0;
	localparam logic [15:0] RST_RESET_DELAY_MS    = 16'd10;

	localparam logic [15:0] HOLD_FOREVER = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  normal_pin_state;
		logic [1:0]  timeout_pin_state;
		logic        reset_after_timeout;
		logic        all_pins_mode;
		logic [7:0]  all_pins_pattern;
		logic [15:0] reset_delay_ms;
	} cfg_t;

endpackage

[rtl/pwdt_req_if.sv]
// Request channel of the pin watchdog timer: valid/ready with request payload.
// Standalone; no package dependency.
interface pwdt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] load_value;

	modport source (output valid, output req_type, output load_value, input ready);
	modport sink (input valid, input req_type, input load_value, output ready);
endinterface

[rtl/pwdt_res_if.sv]
// Result channel of the pin watchdog timer: valid/ready with result payload.
// Standalone; no package dependency.
interface pwdt_res_if;
	logic        valid;
	logic        ready;
	logic        pin_drive_valid;
	logic [1:0]  pin_state;
	logic        all_pins_valid;
	logic [7:0]  all_pins_states;
	logic        reset_request;
	logic [15:0] remaining_ms;

	modport source (output valid, output pin_drive_valid, output pin_state,
		output all_pins_valid, output all_pins_states, output reset_request,
		output remaining_ms, input ready);
	modport sink (input valid, input pin_drive_valid, input pin_state,
		input all_pins_valid, input all_pins_states, input reset_request,
		input remaining_ms, output ready);
endinterface

[rtl/pwdt_cfg_regs.sv]
// APB-style configuration register file of the pin watchdog timer.
// Depends on pwdt_pkg for register indexes, reset values and cfg_t.
module pwdt_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pwdt_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output pwdt_pkg::cfg_t                   cfg
);

	pwdt_pkg::cfg_t                 cfg_q;
	logic [pwdt_pkg::REG_IDX_W-1:0] idx;
	logic                           wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[pwdt_pkg::REG_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_pin_state    <= pwdt_pkg::RST_NORMAL_PIN_STATE;
			cfg_q.timeout_pin_state   <= pwdt_pkg::RST_TIMEOUT_PIN_STATE;
			cfg_q.reset_after_timeout <= 1'b0;
			cfg_q.all_pins_mode       <= 1'b0;
			cfg_q.all_pins_pattern    <= 8'd0;
			cfg_q.reset_delay_ms      <= pwdt_pkg::RST_RESET_DELAY_MS;
		end else if (wr_en) begin
			unique case (idx)
				pwdt_pkg::REG_NORMAL_PIN_STATE:    cfg_q.normal_pin_state    <= pwdata[1:0];
				pwdt_pkg::REG_TIMEOUT_PIN_STATE:   cfg_q.timeout_pin_state   <= pwdata[1:0];
				pwdt_pkg::REG_RESET_AFTER_TIMEOUT: cfg_q.reset_after_timeout <= pwdata[0];
				pwdt_pkg::REG_ALL_PINS_MODE:       cfg_q.all_pins_mode       <= pwdata[0];
				pwdt_pkg::REG_ALL_PINS_PATTERN:    cfg_q.all_pins_pattern    <= pwdata[7:0];
				pwdt_pkg::REG_RESET_DELAY_MS:      cfg_q.reset_delay_ms      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pwdt_pkg::REG_NORMAL_PIN_STATE:    prdata = {30'd0, cfg_q.normal_pin_state};
			pwdt_pkg::REG_TIMEOUT_PIN_STATE:   prdata = {30'd0, cfg_q.timeout_pin_state};
			pwdt_pkg::REG_RESET_AFTER_TIMEOUT: prdata = {31'd0, cfg_q.reset_after_timeout};
			pwdt_pkg::REG_ALL_PINS_MODE:       prdata = {31'd0, cfg_q.all_pins_mode};
			pwdt_pkg::REG_ALL_PINS_PATTERN:    prdata = {24'd0, cfg_q.all_pins_pattern};
			pwdt_pkg::REG_RESET_DELAY_MS:      prdata = {16'd0, cfg_q.reset_delay_ms};
			default:                           prdata = 32'd0;
		endcase
	end

endmodule

[rtl/pwdt_core.sv]
// Watchdog datapath: input register, counter/pattern state and result register.
// Depends on pwdt_pkg, pwdt_req_if and pwdt_res_if.
module pwdt_core #(
	parameter int unsigned PIN_COUNT = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pwdt_pkg::cfg_t cfg,
	pwdt_req_if.sink       req,
	pwdt_res_if.source     rsp
);

	localparam int unsigned PIN_BITS = 2 * PIN_COUNT;
	localparam logic [7:0]  PIN_MASK = 8'((16'd1 << PIN_BITS) - 16'd1);

	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic [15:0] load_value_s1;

	logic [15:0] remaining_q;
	logic [15:0] delay_q;
	logic [7:0]  pattern_q;

	logic        valid_s2;
	logic        pin_drive_valid_s2;
	logic [1:0]  pin_state_s2;
	logic        all_pins_valid_s2;
	logic [7:0]  all_pins_states_s2;
	logic        reset_request_s2;
	logic [15:0] remaining_ms_s2;

	logic        advance;
	logic [15:0] remaining_n;
	logic [15:0] delay_n;
	logic [7:0]  pattern_n;
	logic        drive_v;
	logic [1:0]  drive_s;
	logic        all_v;
	logic [7:0]  all_s;
	logic        rst_req;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_comb begin
		remaining_n = remaining_q;
		delay_n     = delay_q;
		pattern_n   = pattern_q;
		drive_v     = 1'b0;
		drive_s     = 2'd0;
		all_v       = 1'b0;
		all_s       = 8'd0;
		rst_req     = 1'b0;
		unique case (req_type_s1)
			pwdt_pkg::REQ_ARM: begin
				remaining_n = load_value_s1;
				delay_n     = cfg.reset_delay_ms;
				pattern_n   = cfg.all_pins_pattern;
				drive_v     = 1'b1;
				drive_s     = cfg.normal_pin_state;
			end
			pwdt_pkg::REQ_KICK: begin
				remaining_n = load_value_s1;
			end
			pwdt_pkg::REQ_TICK: begin
				if (remaining_q != 16'd0) begin
					remaining_n = remaining_q - 16'd1;
					if (remaining_q == 16'd1) begin
						drive_v = 1'b1;
						drive_s = cfg.timeout_pin_state;
						if (cfg.all_pins_mode) begin
							all_v     = 1'b1;
							all_s     = pattern_q & PIN_MASK;
							pattern_n = pattern_q >> PIN_BITS;
						end
					end
				end else if (delay_q != 16'd0) begin
					if (delay_q != pwdt_pkg::HOLD_FOREVER) begin
						delay_n = delay_q - 16'd1;
					end
				end else if (cfg.reset_after_timeout) begin
					rst_req = 1'b1;
				end else begin
					drive_v = 1'b1;
					drive_s = cfg.normal_pin_state;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			remaining_q <= 16'd0;
			delay_q     <= 16'd0;
			pattern_q   <= 8'd0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2    <= 1'b1;
				remaining_q <= remaining_n;
				delay_q     <= delay_n;
				pattern_q   <= pattern_n;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1   <= req.req_type;
			load_value_s1 <= req.load_value;
		end
		if (advance) begin
			pin_drive_valid_s2 <= drive_v;
			pin_state_s2       <= drive_s;
			all_pins_valid_s2  <= all_v;
			all_pins_states_s2 <= all_s;
			reset_request_s2   <= rst_req;
			remaining_ms_s2    <= remaining_n;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.pin_drive_valid = pin_drive_valid_s2;
	assign rsp.pin_state       = pin_state_s2;
	assign rsp.all_pins_valid  = all_pins_valid_s2;
	assign rsp.all_pins_states = all_pins_states_s2;
	assign rsp.reset_request   = reset_request_s2;
	assign rsp.remaining_ms    = remaining_ms_s2;

endmodule

[rtl/pin_watchdog_timer.sv]
// Pin watchdog timer top level: APB configuration registers and watchdog core.
// Depends on pwdt_pkg, pwdt_req_if, pwdt_res_if, pwdt_cfg_regs and pwdt_core.
// Pipeline: a request passes the input register, then the result register; an untaken result holds it.
// Throughput: one request per cycle while results are taken; the counter update is combinational.
// Reset: asynchronous; counters and pattern clear, registers take their defaults.
module pin_watchdog_timer #(
	parameter int unsigned PIN_COUNT = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pwdt_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	pwdt_req_if.sink                         req,
	pwdt_res_if.source                       rsp
);

	pwdt_pkg::cfg_t cfg;

	pwdt_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pwdt_core #(
		.PIN_COUNT (PIN_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
